// File: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window median filter: default
// sizes, the window register reset value and the cell control structs.
// ----------------------------------------------------------------------------
package swm_pkg;

    // default sizes
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 31;

    // window size register
    localparam int          CFG_WIDTH    = 7;
    localparam int unsigned WINDOW_RESET = 3;

    // controls broadcast to every cell
    typedef struct packed {
        logic step;    // a sample is transferred in this cycle
        logic clear;   // drop every stored sample
        logic full;    // window is full before this sample
        logic rm_le;   // the retiring sample is not greater than the new one
    } swm_bcast_t;

    // status a cell shows its neighbors
    typedef struct packed {
        logic valid;   // cell holds a sample
        logic le;      // stored sample is not greater than the new one
        logic keep;    // cell lies below the insertion slot
    } swm_cstat_t;

endpackage

// File: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted sample row. On each transfer it keeps its sample, takes
// the neighbor above or below, or takes the new sample, so that the row stays
// sorted after the oldest sample retires and the new one slots in.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int AGE_WIDTH    = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  swm_bcast_t              bc,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic [AGE_WIDTH-1:0]    age_last,
    input  logic                    rm_below,
    input  swm_cstat_t              lo_stat,
    input  logic [SAMPLE_WIDTH-1:0] lo_value,
    input  logic [AGE_WIDTH-1:0]    lo_age,
    input  swm_cstat_t              hi_stat,
    input  logic [SAMPLE_WIDTH-1:0] hi_value,
    input  logic [AGE_WIDTH-1:0]    hi_age,
    output swm_cstat_t              stat,
    output logic                    rm,
    output logic [SAMPLE_WIDTH-1:0] value,
    output logic [AGE_WIDTH-1:0]    age,
    output logic [SAMPLE_WIDTH-1:0] value_next
);

    logic [SAMPLE_WIDTH-1:0] value_reg;
    logic [AGE_WIDTH-1:0]    age_reg;
    logic [AGE_WIDTH-1:0]    age_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    le;
    logic                    keep;

    // local compares
    assign le   = valid_reg && (value_reg <= sample);
    assign rm   = bc.full && valid_reg && (age_reg == age_last);
    assign keep = bc.rm_le ? hi_stat.le : le;

    assign stat  = '{valid: valid_reg, le: le, keep: keep};
    assign value = value_reg;
    assign age   = age_reg;

    // pick the new content of this slot
    always_comb
    begin
        if (keep)
        begin
            if (rm_below || rm)
            begin
                value_next = hi_value;
                age_next   = hi_age + AGE_WIDTH'(1);
            end
            else
            begin
                value_next = value_reg;
                age_next   = age_reg + AGE_WIDTH'(1);
            end
        end
        else if (lo_stat.keep)
        begin
            value_next = sample;
            age_next   = '0;
        end
        else if (rm_below)
        begin
            value_next = value_reg;
            age_next   = age_reg + AGE_WIDTH'(1);
        end
        else
        begin
            value_next = lo_value;
            age_next   = lo_age + AGE_WIDTH'(1);
        end
    end

    // occupancy grows from the bottom until the window is full
    assign valid_next = bc.full ? valid_reg : lo_stat.valid;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bc.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (bc.step)
        begin
            valid_reg <= valid_next;
        end
    end

    // sample and age
    always_ff @(posedge clk)
    begin
        if (bc.step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// File: rtl/swm_outq.sv
// ----------------------------------------------------------------------------
// swm_outq
// Two-entry result queue: an output register and a skid register, so a new
// sample can be taken while a finished median still waits downstream.
// ----------------------------------------------------------------------------
module swm_outq
    import swm_pkg::*;
#(
    parameter int DATA_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] out_data
);

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  skid_valid_reg;
    logic [DATA_WIDTH-1:0] skid_data_reg;
    logic                  take;

    assign take      = out_valid_reg && !out_stall;
    assign busy      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // queue data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

// File: rtl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running lower median over the newest window_size samples, kept in a row of
// compare-and-shift cells sorted by value, each tagged with its sample's age.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    sample, end_of_stream
//   out      source     out_valid / out_stall  median
//   cfg      sink       cfg_valid / cfg_ready  window_size
//
// One sample per clock while in_stall is low; a median is registered for the
// transfer that fills or advances the full window. The row of cells updates
// on each transfer, so the clock rate is set by the cell row and the median
// select. Reset clears the row and sets window_size to 3. A config write
// clears the row. in_stall rises only while both result registers are occupied.
// ----------------------------------------------------------------------------
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    end_of_stream,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_WIDTH-1:0] median,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_WIDTH-1:0]    window_size
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
    localparam int RESET_EFF = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;
    localparam logic [WINDOW_MAX-1:0] ONES = '1;

    logic                    cfg_wr;
    logic                    accept;
    logic                    full;
    logic                    produce;
    logic [CW-1:0]           fill_count_reg;
    logic [CW-1:0]           w_eff_reg;
    logic [AW-1:0]           age_last_reg;
    logic [AW-1:0]           mid_reg;
    logic [EW-1:0]           wsz_ext;
    logic [CW-1:0]           w_eff_next;
    logic [WINDOW_MAX-1:0]   rm_vec;
    logic [WINDOW_MAX-1:0]   le_vec;
    logic [WINDOW_MAX-1:0]   valid_vec;
    logic [WINDOW_MAX-1:0]   rm_below;
    logic                    q_busy;
    swm_bcast_t              bc;
    swm_cstat_t              stat_arr   [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] value_arr  [WINDOW_MAX];
    logic [AW-1:0]           age_arr    [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] vnext_arr  [WINDOW_MAX];

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_stall  = q_busy;
    assign accept    = in_valid && !in_stall;

    // window length after the zero and upper clamps
    assign wsz_ext = EW'(window_size);
    always_comb
    begin
        if (wsz_ext == '0)
        begin
            w_eff_next = CW'(1);
        end
        else if (wsz_ext > EW'(WINDOW_MAX))
        begin
            w_eff_next = CW'(WINDOW_MAX);
        end
        else
        begin
            w_eff_next = CW'(wsz_ext);
        end
    end

    // window register and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg      <= CW'(RESET_EFF);
            age_last_reg   <= AW'(RESET_EFF - 1);
            mid_reg        <= AW'((RESET_EFF - 1) / 2);
            fill_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            w_eff_reg      <= w_eff_next;
            age_last_reg   <= AW'(w_eff_next - CW'(1));
            mid_reg        <= AW'((w_eff_next - CW'(1)) >> 1);
            fill_count_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_stream)
            begin
                fill_count_reg <= '0;
            end
            else if (!full)
            begin
                fill_count_reg <= fill_count_reg + CW'(1);
            end
        end
    end

    assign full    = (fill_count_reg == w_eff_reg);
    assign produce = accept && (full || (fill_count_reg + CW'(1) == w_eff_reg));

    // controls for the cell row
    assign bc = '{step:  accept,
                  clear: cfg_wr || (accept && end_of_stream),
                  full:  full,
                  rm_le: |(rm_vec & le_vec)};

    // row of sorted cells
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cstat_t              lo_stat;
        swm_cstat_t              hi_stat;
        logic [SAMPLE_WIDTH-1:0] lo_value;
        logic [SAMPLE_WIDTH-1:0] hi_value;
        logic [AW-1:0]           lo_age;
        logic [AW-1:0]           hi_age;

        // a retiring sample somewhere below this slot
        assign rm_below[i] = |(rm_vec & (ONES >> (WINDOW_MAX - i)));
        assign le_vec[i]    = stat_arr[i].le;
        assign valid_vec[i] = stat_arr[i].valid;

        if (i == 0)
        begin : g_lo_edge
            assign lo_stat  = '{valid: 1'b1, le: 1'b1, keep: 1'b1};
            assign lo_value = '0;
            assign lo_age   = '0;
        end
        else
        begin : g_lo
            assign lo_stat  = stat_arr[i-1];
            assign lo_value = value_arr[i-1];
            assign lo_age   = age_arr[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_hi_edge
            assign hi_stat  = '0;
            assign hi_value = '0;
            assign hi_age   = '0;
        end
        else
        begin : g_hi
            assign hi_stat  = stat_arr[i+1];
            assign hi_value = value_arr[i+1];
            assign hi_age   = age_arr[i+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bc         (bc),
            .sample     (sample),
            .age_last   (age_last_reg),
            .rm_below   (rm_below[i]),
            .lo_stat    (lo_stat),
            .lo_value   (lo_value),
            .lo_age     (lo_age),
            .hi_stat    (hi_stat),
            .hi_value   (hi_value),
            .hi_age     (hi_age),
            .stat       (stat_arr[i]),
            .rm         (rm_vec[i]),
            .value      (value_arr[i]),
            .age        (age_arr[i]),
            .value_next (vnext_arr[i])
        );
    end

    // result queue, fed from the middle slot of the updated row
    swm_outq #(
        .DATA_WIDTH (SAMPLE_WIDTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (produce),
        .push_data (vnext_arr[mid_reg]),
        .busy      (q_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (median)
    );

    // fill count never passes the window length
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= w_eff_reg)
        else $error("fill count above window length");

    // occupied cells match the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_count_reg))
        else $error("cell occupancy differs from fill count");

    // a full window retires exactly one sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |-> $onehot(rm_vec))
        else $error("retiring sample not unique");

    // a produced median leaves a median waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> out_valid)
        else $error("median lost");

endmodule

// File: dv/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Watches the sample, median and window size channels of the sliding window
// median filter. It keeps its own copy of the current stream and predicts
// each lower median. Every median transfer is compared with the oldest
// prediction. It reports the number of predictions still open and the
// number of failures.
// ----------------------------------------------------------------------------
module swm_checker
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    end_of_stream,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [SAMPLE_WIDTH-1:0] median,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_WIDTH-1:0]    window_size,
    output int                      pending,
    output int                      fail_count
);

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;

    sample_t              stream_q[$];   // current stream, oldest first
    sample_t              median_q[$];   // predicted medians in order
    logic [CFG_WIDTH-1:0] window_reg;

    // window length in use: zero acts as one, large values saturate
    function automatic int window_span(input logic [CFG_WIDTH-1:0] w);
        int n;
        n = int'(w);
        if (n == 0)
            n = 1;
        if (n > WINDOW_MAX)
            n = WINDOW_MAX;
        return n;
    endfunction

    // element of the given rank in ascending order of the stored stream
    function automatic sample_t ranked_sample(input int rank);
        sample_t pick;
        int      below;
        int      not_above;
        pick = '0;
        foreach (stream_q[i])
        begin
            below     = 0;
            not_above = 0;
            foreach (stream_q[j])
            begin
                if (stream_q[j] < stream_q[i])
                    below++;
                if (stream_q[j] <= stream_q[i])
                    not_above++;
            end
            if (below <= rank && rank < not_above)
                pick = stream_q[i];
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sample_t want;
        int      span;
        if (!rst_n)
        begin
            stream_q.delete();
            median_q.delete();
            window_reg = WINDOW_RESET[CFG_WIDTH-1:0];
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // median transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (median_q.size() == 0)
                begin
                    $error("median: expected none, actual %0d", median);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = median_q.pop_front();
                    if (median !== want)
                    begin
                        $error("median: expected %0d, actual %0d", want, median);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            // window size write starts a fresh stream
            if (cfg_valid && cfg_ready)
            begin
                window_reg = window_size;
                stream_q.delete();
            end

            // sample transfer: retire the oldest, add the newest
            if (in_valid && !in_stall)
            begin
                span = window_span(window_reg);
                if (stream_q.size() == span)
                    void'(stream_q.pop_front());
                stream_q.push_back(sample);
                if (stream_q.size() == span)
                    median_q.push_back(ranked_sample((span - 1) / 2));
                if (end_of_stream)
                    stream_q.delete();
            end

            pending <= median_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sliding window median filter. A directed
// opening covers extreme samples, equal samples, even windows, pass-through,
// end of stream before and on a full window and a window write that drops a
// partial stream. Random phases then sweep the window size, with bursty
// sample traffic and a stalling receiver. The checker beside the block
// predicts and compares every median.
// ----------------------------------------------------------------------------
module tb_top;

    import swm_pkg::*;

    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 150;
    localparam int PLANNED_WINDOWS = 12;
    localparam int PHASES         = 13;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [SW-1:0]        sample        = '0;
    logic                 end_of_stream = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [SW-1:0]        median;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_WIDTH-1:0] window_size   = '0;

    int pending;
    int fail_count;
    int burst_left   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    // window sizes swept by the random phases, extremes first
    int window_plan [PLANNED_WINDOWS] = '{64, 127, 0, 1, 2, 65, 4, 5, 3, 42, 85, 31};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sliding_window_median i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median        (median),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_size   (window_size)
    );

    swm_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median        (median),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_size   (window_size),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // receiver stalls in stretches of random length
    always @(negedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= $urandom_range(0, 23);
            out_stall  <= ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** sliding_window_median: FAILED **");
            $finish;
        end
    end

    // sender works in bursts with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // one sample transfer
    task automatic send_sample(input logic [SW-1:0] value, input logic last);
        pace_sender();
        @(negedge clk);
        in_valid      <= 1'b1;
        sample        <= value;
        end_of_stream <= last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait for every predicted median
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // window size write while the block is idle
    task automatic write_window(input logic [CFG_WIDTH-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid   <= 1'b1;
        window_size <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mix of wide random, small repeated and extreme samples
    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SW'($urandom());
            5, 6, 7:       return SW'($urandom_range(0, 15));
            8:             return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default:       return ~SW'($urandom_range(0, 15));
        endcase
    endfunction

    initial
    begin
        int            req;
        int            span;
        logic [SW-1:0] top_value;

        top_value = '1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset window of three: extremes, alternating bits, equal samples
        send_sample(top_value, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SW'(32'h5555_5555), 1'b0);
        send_sample(SW'(32'h2AAA_AAAA), 1'b0);
        send_sample(SW'(10), 1'b0);
        send_sample(SW'(10), 1'b0);
        send_sample(SW'(10), 1'b1);
        // end of stream before the window fills
        send_sample(SW'(1), 1'b0);
        send_sample(SW'(2), 1'b1);
        send_sample(SW'(3), 1'b0);
        send_sample(SW'(2), 1'b0);
        send_sample(SW'(1), 1'b1);

        // zero window acts as pass-through
        write_window('0);
        send_sample(top_value, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SW'(77), 1'b1);

        // even window takes the lower median
        write_window(CFG_WIDTH'(2));
        send_sample(SW'(9), 1'b0);
        send_sample(SW'(4), 1'b0);
        send_sample(SW'(6), 1'b0);
        send_sample(SW'(6), 1'b0);

        // a write drops a partial stream
        write_window(CFG_WIDTH'(3));
        send_sample(SW'(100), 1'b0);
        send_sample(SW'(200), 1'b0);
        write_window(CFG_WIDTH'(4));
        send_sample(SW'(1), 1'b0);
        send_sample(SW'(2), 1'b0);
        send_sample(SW'(3), 1'b0);
        send_sample(SW'(4), 1'b0);

        // random phases over the window sizes
        for (int p = 0; p < PHASES; p++)
        begin
            req = (p < PLANNED_WINDOWS) ? window_plan[p] : $urandom_range(0, 127);
            write_window(CFG_WIDTH'(req));
            span = (req == 0) ? 1 : ((req > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : req);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                send_sample(random_sample(), $urandom_range(1, 2 * span + 2) == 1);
            end
        end

        drain();
        if (fail_count == 0)
            $display("** sliding_window_median: PASSED **");
        else
            $display("** sliding_window_median: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_outq.sv
rtl/sliding_window_median.sv
dv/swm_checker.sv
dv/tb_top.sv
